[rtl/lsfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LIN slave frame receiver package
// Shared widths, phase codes, protocol bytes and the checksum add helper.
// ----------------------------------------------------------------------------
package lsfr_pkg;

    // Slot table size and data buffer geometry.
    localparam int NUM_SLOTS      = 4;
    localparam int MAX_DATA_BYTES = 8;
    localparam int SLOT_W         = 2;
    localparam int SLOT_CNT       = 2 ** SLOT_W;
    localparam int BYTE_W         = 8;
    localparam int LANES          = 8;
    localparam int LANE_W         = 3;
    localparam int DATA_W         = LANES * BYTE_W;
    localparam int LEN_W          = 4;
    localparam int ENTRY_W        = BYTE_W + LEN_W;
    localparam int CFG_IDX_W      = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT3 = 3'd3;

    // Frame phase codes.
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_BREAK = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SYNC  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ID    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CKSUM = 3'd4;

    // Protocol bytes.
    localparam logic [BYTE_W-1:0] BREAK_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
    localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_DATA_BYTES);

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [DATA_W-1:0]  frame_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    // Eight-bit add with the carry folded back into bit 0.
    function automatic byte_t add_carry(input byte_t a, input byte_t b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BYTE_W] ? (s[BYTE_W-1:0] + byte_t'(1)) : s[BYTE_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/lin_slave_frame_receiver_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LIN slave frame receiver core
// Takes UART bytes of a LIN frame, matches the ID against four slot entries,
// stores the data bytes in a per-slot buffer memory and checks the enhanced
// checksum. A good frame yields the slot number and its full 8-byte buffer.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                  | Role
//  --------+----------------------------------------+---------------------------
//  s_      | s_valid s_ready s_rx_byte              | one received byte per item
//  m_      | m_valid m_ready m_slot_index           | one item per good frame
//          | m_frame_data                           |
//  cfg_    | cfg_we cfg_index cfg_wdata             | slot entry writes
//
// A new byte may follow every cycle while s_ready is high.
// Slot buffers sit in a 4 x 64-bit memory with registered read; the ID byte
// starts the read and the data bytes update a working copy that is written
// back on every byte. A result stays in the output register until taken; only
// a checksum byte that meets a waiting result is held off (s_ready low).
// Reset is synchronous and active low; the buffers read as zero until written.
// ----------------------------------------------------------------------------
module lin_slave_frame_receiver_core (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [lsfr_pkg::BYTE_W-1:0]        s_rx_byte,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [lsfr_pkg::SLOT_W-1:0]        m_slot_index,
    output logic [lsfr_pkg::DATA_W-1:0]        m_frame_data,
    input  wire                                cfg_we,
    input  wire  [lsfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [lsfr_pkg::ENTRY_W-1:0]       cfg_wdata
);

    // Slot entry registers.
    lsfr_pkg::entry_t entry_reg [lsfr_pkg::SLOT_CNT];

    // Frame control state.
    logic [lsfr_pkg::PHASE_W-1:0] phase_reg,   phase_next;
    lsfr_pkg::slot_t              slot_reg;
    logic [lsfr_pkg::LEN_W-1:0]   count_reg;
    logic [lsfr_pkg::LEN_W-1:0]   len_reg;
    lsfr_pkg::byte_t              sum_reg;

    // Buffer memory, its valid bits and the working copy.
    lsfr_pkg::frame_t             buf_mem [lsfr_pkg::SLOT_CNT];
    logic [lsfr_pkg::SLOT_CNT-1:0] buf_valid_reg;
    lsfr_pkg::frame_t             rd_data_reg;
    logic                         rd_valid_reg;
    logic                         fresh_reg;
    lsfr_pkg::frame_t             work_reg;

    // Output register.
    logic                         m_valid_reg;
    lsfr_pkg::slot_t              m_slot_reg;
    lsfr_pkg::frame_t             m_data_reg;

    logic                         accept;
    logic                         id_hit;
    lsfr_pkg::slot_t              id_slot;
    logic [lsfr_pkg::LEN_W-1:0]   id_len;
    lsfr_pkg::frame_t             cur_buf;
    lsfr_pkg::frame_t             new_buf;
    logic [lsfr_pkg::LEN_W-1:0]   count_inc;
    logic                         cksum_ok;
    logic                         produce;

    // Only a checksum byte needs room in the output register.
    assign s_ready = !((phase_reg == lsfr_pkg::PH_CKSUM) && m_valid_reg && !m_ready);
    assign accept  = s_valid && s_ready;

    // ID lookup: the highest-numbered enabled matching slot wins.
    always_comb begin
        logic [lsfr_pkg::LEN_W-1:0] l;
        id_hit  = 1'b0;
        id_slot = '0;
        id_len  = '0;
        for (int i = 0; i < lsfr_pkg::NUM_SLOTS; i++) begin
            l = entry_reg[i][lsfr_pkg::ENTRY_W-1:lsfr_pkg::BYTE_W];
            if (l != '0 && entry_reg[i][lsfr_pkg::BYTE_W-1:0] == s_rx_byte) begin
                id_hit  = 1'b1;
                id_slot = lsfr_pkg::SLOT_W'(i);
                id_len  = (l > lsfr_pkg::MAX_LEN) ? lsfr_pkg::MAX_LEN : l;
            end
        end
    end

    // Current buffer: fresh memory read right after the ID, else the working copy.
    always_comb begin
        if (fresh_reg) begin
            cur_buf = rd_valid_reg ? rd_data_reg : '0;
        end else begin
            cur_buf = work_reg;
        end
    end

    // Replace the addressed byte lane with the received byte.
    always_comb begin
        new_buf = cur_buf;
        for (int k = 0; k < lsfr_pkg::LANES; k++) begin
            if (count_reg[lsfr_pkg::LANE_W-1:0] == lsfr_pkg::LANE_W'(k)) begin
                new_buf[k*lsfr_pkg::BYTE_W +: lsfr_pkg::BYTE_W] = s_rx_byte;
            end
        end
    end

    assign count_inc = count_reg + lsfr_pkg::LEN_W'(1);
    assign cksum_ok  = (~sum_reg == s_rx_byte);
    assign produce   = accept && (phase_reg == lsfr_pkg::PH_CKSUM) && cksum_ok;

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            lsfr_pkg::PH_SYNC: begin
                phase_next = (s_rx_byte == lsfr_pkg::SYNC_BYTE) ? lsfr_pkg::PH_ID
                                                                : lsfr_pkg::PH_BREAK;
            end
            lsfr_pkg::PH_ID: begin
                phase_next = id_hit ? lsfr_pkg::PH_DATA : lsfr_pkg::PH_BREAK;
            end
            lsfr_pkg::PH_DATA: begin
                phase_next = (count_inc >= len_reg) ? lsfr_pkg::PH_CKSUM
                                                    : lsfr_pkg::PH_DATA;
            end
            lsfr_pkg::PH_CKSUM: begin
                phase_next = lsfr_pkg::PH_BREAK;
            end
            default: begin
                phase_next = (s_rx_byte == lsfr_pkg::BREAK_BYTE) ? lsfr_pkg::PH_SYNC
                                                                 : lsfr_pkg::PH_BREAK;
            end
        endcase
    end

    // Configuration writes; indexes past the table are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lsfr_pkg::SLOT_CNT; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                lsfr_pkg::CFG_SLOT0: entry_reg[0] <= cfg_wdata;
                lsfr_pkg::CFG_SLOT1: entry_reg[1] <= cfg_wdata;
                lsfr_pkg::CFG_SLOT2: entry_reg[2] <= cfg_wdata;
                lsfr_pkg::CFG_SLOT3: entry_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= lsfr_pkg::PH_BREAK;
            slot_reg      <= '0;
            count_reg     <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            fresh_reg     <= 1'b0;
            buf_valid_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            if (phase_reg == lsfr_pkg::PH_ID && id_hit) begin
                slot_reg  <= id_slot;
                len_reg   <= id_len;
                count_reg <= '0;
                sum_reg   <= s_rx_byte;
                fresh_reg <= 1'b1;
            end
            if (phase_reg == lsfr_pkg::PH_DATA) begin
                count_reg               <= count_inc;
                sum_reg                 <= lsfr_pkg::add_carry(sum_reg, s_rx_byte);
                fresh_reg               <= 1'b0;
                buf_valid_reg[slot_reg] <= 1'b1;
            end
        end
    end

    // Buffer memory: read on the ID byte, write back on every data byte.
    always_ff @(posedge aclk) begin
        if (accept && phase_reg == lsfr_pkg::PH_ID) begin
            rd_data_reg  <= buf_mem[id_slot];
            rd_valid_reg <= buf_valid_reg[id_slot];
        end
        if (accept && phase_reg == lsfr_pkg::PH_DATA) begin
            buf_mem[slot_reg] <= new_buf;
            work_reg          <= new_buf;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (produce) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            m_slot_reg <= slot_reg;
            m_data_reg <= cur_buf;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_slot_index = m_slot_reg;
    assign m_frame_data = m_data_reg;

endmodule
`default_nettype wire

[rtl/lsfr_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LIN slave frame receiver port checker
// Watches the top-level ports for result hold, ordering, slot range, input stalls and reset behavior.
// ----------------------------------------------------------------------------
module lsfr_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_valid,
    input wire                                s_ready,
    input wire                                m_valid,
    input wire                                m_ready,
    input wire [lsfr_pkg::SLOT_W-1:0]         m_slot_index,
    input wire [lsfr_pkg::DATA_W-1:0]         m_frame_data
);

    // A waiting result holds still until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot_index)
                                && $stable(m_frame_data))
        else $error("result changed while stalled");

    // Reset clears the result register.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A new result only follows an accepted byte.
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid ##1 m_valid |-> $past(s_valid && s_ready))
        else $error("result without an accepted item");

    // Slots past the table are never reported.
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_slot_index < lsfr_pkg::SLOT_W'(lsfr_pkg::NUM_SLOTS - 1) ||
                    m_slot_index == lsfr_pkg::SLOT_W'(lsfr_pkg::NUM_SLOTS - 1))
        else $error("slot index out of range");

    // Input is blocked only while a result waits.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

endmodule

bind lin_slave_frame_receiver_core lsfr_checker u_lsfr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_slot_index (m_slot_index),
    .m_frame_data (m_frame_data)
);
`default_nettype wire
